// ----- sv/pl0ts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, token codes and keyword table of the PL/0 token scanner.
package pl0ts_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int KEYWORD_CHARS_DEFAULT = 8;

   localparam int KW_COUNT     = 13;
   localparam int KW_TEXT_BITS = 64;

   localparam logic [2:0] KIND_PUNCT = 3'd0;
   localparam logic [2:0] KIND_KEY   = 3'd1;
   localparam logic [2:0] KIND_IDENT = 3'd2;
   localparam logic [2:0] KIND_NUM   = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;
   localparam logic [2:0] KIND_ERR   = 3'd5;

   localparam logic [3:0] P_LT      = 4'd7;
   localparam logic [3:0] P_GT      = 4'd8;
   localparam logic [3:0] P_NE      = 4'd12;
   localparam logic [3:0] P_LE      = 4'd13;
   localparam logic [3:0] P_GE      = 4'd14;
   localparam logic [3:0] P_BECOMES = 4'd15;

   localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUMBER,
      MODE_LT,
      MODE_GT,
      MODE_COLON,
      MODE_ERROR
   } mode_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  code;
      logic [30:0] value;
      logic [15:0] start;
      logic [15:0] length;
   } rsp_type;

   typedef struct packed {
      logic     emit;
      rsp_type  item;
      mode_type mode;
   } flush_type;

   // Keyword text, right-justified, first character in the highest used byte.
   function automatic logic [KW_TEXT_BITS-1:0] kw_text(input logic [3:0] k);
      logic [KW_TEXT_BITS-1:0] t;
      case (k)
         4'd0:    t = "begin";
         4'd1:    t = "end";
         4'd2:    t = "if";
         4'd3:    t = "then";
         4'd4:    t = "while";
         4'd5:    t = "do";
         4'd6:    t = "return";
         4'd7:    t = "function";
         4'd8:    t = "var";
         4'd9:    t = "const";
         4'd10:   t = "odd";
         4'd11:   t = "writeln";
         4'd12:   t = "write";
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [15:0] kw_len(input logic [3:0] k);
      logic [15:0] l;
      case (k)
         4'd0:    l = 16'd5;
         4'd1:    l = 16'd3;
         4'd2:    l = 16'd2;
         4'd3:    l = 16'd4;
         4'd4:    l = 16'd5;
         4'd5:    l = 16'd2;
         4'd6:    l = 16'd6;
         4'd7:    l = 16'd8;
         4'd8:    l = 16'd3;
         4'd9:    l = 16'd5;
         4'd10:   l = 16'd3;
         4'd11:   l = 16'd7;
         4'd12:   l = 16'd5;
         default: l = 16'd0;
      endcase
      return l;
   endfunction

endpackage

// ----- sv/pl0_token_scanner.sv -----
`timescale 1ns / 1ps
// Top level of the PL/0 token scanner: byte classification, token state and result buffer.
//
// Source bytes enter one beat per cycle on req_; each byte is scanned in the cycle it is
// accepted and the tokens it completes (none, one, two or three) are written into a
// three-entry result buffer that drains one beat per cycle on rsp_ while rsp_tready is high.
// A new byte is taken whenever the buffer is empty or its final entry leaves in the same
// cycle, so text that yields at most one token per byte streams at one byte per cycle; a
// byte that closes two or three tokens holds the input while the buffer drains.
// Whitespace is skipped, an error result is followed by dropping bytes up to the one marked
// tlast, and that final byte flushes the pending token and adds an end token, after which
// offsets restart at zero. rsp_tlast marks the last token caused by one source byte.
module pl0_token_scanner
   import pl0ts_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // code[3:0], value[34:4], start_res[50:35], length[66:51]
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast
);

   localparam int WB = KEYWORD_CHARS * 8;

   mode_type               mode_ff, mode_in;
   logic [WB-1:0]          word_ff, word_in;
   logic [15:0]            len_ff, len_in;
   logic [30:0]            acc_ff, acc_in;
   logic [POSITION_BITS-1:0] beg_ff, beg_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   rsp_type    slot_ff [3];
   rsp_type    slot_in [3];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] rd_ff;
   logic [1:0] rd_next;

   logic       accept;
   logic       pop;
   rsp_type    head;

   function automatic rsp_type mk(input logic [2:0] kind, input logic [3:0] code,
                                  input logic [30:0] value,
                                  input logic [POSITION_BITS-1:0] start,
                                  input logic [15:0] length);
      rsp_type r;
      r.kind   = kind;
      r.code   = code;
      r.value  = value;
      r.start  = 16'(start);
      r.length = length;
      return r;
   endfunction

   function automatic flush_type flush(input mode_type m, input logic [WB-1:0] w,
                                       input logic [15:0] l, input logic [30:0] a,
                                       input logic [POSITION_BITS-1:0] b);
      flush_type f;
      logic      hit;
      logic [3:0] idx;
      hit = 1'b0;
      idx = 4'd0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (l == kw_len(4'(k)) && w[KW_TEXT_BITS-1:0] == kw_text(4'(k))) begin
            hit = 1'b1;
            idx = 4'(k);
         end
      end
      f.emit = 1'b1;
      f.mode = MODE_IDLE;
      f.item = mk(KIND_ERR, 4'd0, 31'd0, b, 16'd1);
      unique case (m)
         MODE_WORD: begin
            f.item = hit ? mk(KIND_KEY, idx, 31'd0, b, l) : mk(KIND_IDENT, 4'd0, 31'd0, b, l);
         end
         MODE_NUMBER: f.item = mk(KIND_NUM, 4'd0, a, b, l);
         MODE_LT:     f.item = mk(KIND_PUNCT, P_LT, 31'd0, b, 16'd1);
         MODE_GT:     f.item = mk(KIND_PUNCT, P_GT, 31'd0, b, 16'd1);
         MODE_COLON:  f.mode = MODE_ERROR;
         default: begin
            f.emit = 1'b0;
            f.mode = m;
         end
      endcase
      return f;
   endfunction

   function automatic logic [4:0] single_code(input logic [7:0] c);
      logic [4:0] r;
      case (c)
         "+":     r = {1'b1, 4'd0};
         "-":     r = {1'b1, 4'd1};
         "*":     r = {1'b1, 4'd2};
         "/":     r = {1'b1, 4'd3};
         "(":     r = {1'b1, 4'd4};
         ")":     r = {1'b1, 4'd5};
         "=":     r = {1'b1, 4'd6};
         "<":     r = {1'b1, 4'd7};
         ">":     r = {1'b1, 4'd8};
         ",":     r = {1'b1, 4'd9};
         ".":     r = {1'b1, 4'd10};
         ";":     r = {1'b1, 4'd11};
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // Scan one byte
   always_comb begin
      logic [7:0]  c;
      logic        used;
      logic        is_digit;
      logic        is_alpha;
      logic        is_space;
      logic [1:0]  n;
      logic [35:0] prod;
      logic [4:0]  sc;
      flush_type   f;

      c        = req_tdata;
      is_digit = (c >= "0") && (c <= "9");
      is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
      is_space = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
      sc       = single_code(c);
      prod     = {2'b0, acc_ff, 3'b0} + {4'b0, acc_ff, 1'b0} + {32'b0, 4'(c - "0")};
      f        = '0;

      mode_in = mode_ff;
      word_in = word_ff;
      len_in  = len_ff;
      acc_in  = acc_ff;
      beg_in  = beg_ff;
      pos_in  = pos_ff;
      used    = 1'b0;
      n       = 2'd0;
      for (int i = 0; i < 3; i++) begin
         slot_in[i] = slot_ff[i];
      end

      unique case (mode_ff)
         MODE_ERROR: used = 1'b1;
         MODE_LT: begin
            if (c == ">" || c == "=") begin
               slot_in[n] = mk(KIND_PUNCT, (c == ">") ? P_NE : P_LE, 31'd0, beg_ff, 16'd2);
               n = 2'(n + 2'd1);
               mode_in = MODE_IDLE;
               used = 1'b1;
            end
         end
         MODE_GT: begin
            if (c == "=") begin
               slot_in[n] = mk(KIND_PUNCT, P_GE, 31'd0, beg_ff, 16'd2);
               n = 2'(n + 2'd1);
               mode_in = MODE_IDLE;
               used = 1'b1;
            end
         end
         MODE_COLON: begin
            if (c == "=") begin
               slot_in[n] = mk(KIND_PUNCT, P_BECOMES, 31'd0, beg_ff, 16'd2);
               mode_in = MODE_IDLE;
            end else begin
               slot_in[n] = mk(KIND_ERR, 4'd0, 31'd0, beg_ff, 16'd1);
               mode_in = MODE_ERROR;
            end
            n = 2'(n + 2'd1);
            used = 1'b1;
         end
         MODE_WORD: begin
            if (is_alpha || is_digit) begin
               if (len_ff < 16'(KEYWORD_CHARS)) begin
                  word_in = {word_ff[WB-9:0], c};
               end
               if (len_ff != LEN_MAX) begin
                  len_in = len_ff + 16'd1;
               end
               used = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit) begin
               acc_in = (prod > {5'b0, NUM_MAX}) ? NUM_MAX : prod[30:0];
               if (len_ff != LEN_MAX) begin
                  len_in = len_ff + 16'd1;
               end
               used = 1'b1;
            end
         end
         default: used = 1'b0;
      endcase

      if (!used) begin
         f = flush(mode_ff, word_ff, len_ff, acc_ff, beg_ff);
         if (f.emit) begin
            slot_in[n] = f.item;
            n = 2'(n + 2'd1);
         end
         mode_in = f.mode;
         if (is_space) begin
            mode_in = f.mode;
         end else if (c == "<") begin
            mode_in = MODE_LT;
            beg_in  = pos_ff;
         end else if (c == ">") begin
            mode_in = MODE_GT;
            beg_in  = pos_ff;
         end else if (c == ":") begin
            mode_in = MODE_COLON;
            beg_in  = pos_ff;
         end else if (is_digit) begin
            mode_in = MODE_NUMBER;
            acc_in  = 31'(c - "0");
            len_in  = 16'd1;
            beg_in  = pos_ff;
         end else if (is_alpha) begin
            mode_in = MODE_WORD;
            word_in = {{(WB-8){1'b0}}, c};
            len_in  = 16'd1;
            beg_in  = pos_ff;
         end else if (sc[4]) begin
            slot_in[n] = mk(KIND_PUNCT, sc[3:0], 31'd0, pos_ff, 16'd1);
            n = 2'(n + 2'd1);
         end else begin
            slot_in[n] = mk(KIND_ERR, 4'd0, 31'd0, pos_ff, 16'd1);
            n = 2'(n + 2'd1);
            mode_in = MODE_ERROR;
         end
      end

      if (req_tlast) begin
         f = flush(mode_in, word_in, len_in, acc_in, beg_in);
         if (f.emit) begin
            slot_in[n] = f.item;
            n = 2'(n + 2'd1);
         end
         slot_in[n] = mk(KIND_END, 4'd0, 31'd0, POSITION_BITS'(pos_ff + 1'b1), 16'd0);
         n = 2'(n + 2'd1);
         mode_in = MODE_IDLE;
         len_in  = 16'd0;
         acc_in  = 31'd0;
         beg_in  = '0;
         pos_in  = '0;
      end else begin
         pos_in = POSITION_BITS'(pos_ff + 1'b1);
      end

      cnt_in = n;
   end

   assign rd_next    = 2'(rd_ff + 2'd1);
   assign rsp_tvalid = (rd_ff != cnt_ff);
   assign req_tready = !rsp_tvalid || (rsp_tready && (rd_next == cnt_ff));
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff  <= 16'd0;
         acc_ff  <= 31'd0;
         beg_ff  <= '0;
         pos_ff  <= '0;
         cnt_ff  <= 2'd0;
         rd_ff   <= 2'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
         beg_ff  <= beg_in;
         pos_ff  <= pos_in;
         cnt_ff  <= cnt_in;
         rd_ff   <= 2'd0;
      end else if (pop) begin
         rd_ff   <= rd_next;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
         for (int i = 0; i < 3; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   always_comb begin
      case (rd_ff)
         2'd1:    head = slot_ff[1];
         2'd2:    head = slot_ff[2];
         default: head = slot_ff[0];
      endcase
   end

   assign rsp_tdata = {5'b0, head.length, head.start, head.value, head.code};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = (rd_next == cnt_ff);

endmodule

// ----- tb/sv/pl0ts_checker.sv -----
`timescale 1ns / 1ps
// Token checker for the PL/0 token scanner: watches both streams, predicts tokens, compares.
module pl0ts_checker
   import pl0ts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          tokens_due
);

   localparam int         WORD_KEEP   = KEYWORD_CHARS_DEFAULT;
   localparam logic [95:0] PUNCT_CHARS = "+-*/()=<>,.;";
   localparam int         PUNCT_COUNT = 12;

   typedef struct packed {
      logic    closes_byte;
      rsp_type tok;
   } token_beat;

   mode_type    scan_state;
   logic [7:0]  word_bytes [WORD_KEEP];
   int          word_len;
   longint      number_val;
   logic [15:0] token_at;
   logic [15:0] byte_at;
   token_beat   due_tokens [$];
   token_beat   byte_tokens [$];

   function automatic string keyword(input int k);
      case (k)
         0:  return "begin";
         1:  return "end";
         2:  return "if";
         3:  return "then";
         4:  return "while";
         5:  return "do";
         6:  return "return";
         7:  return "function";
         8:  return "var";
         9:  return "const";
         10: return "odd";
         11: return "writeln";
         12: return "write";
         default: return "";
      endcase
   endfunction

   function automatic int punct_code(input logic [7:0] c);
      for (int k = 0; k < PUNCT_COUNT; k++)
         if (PUNCT_CHARS[8*(PUNCT_COUNT-1-k) +: 8] == c) return k;
      return -1;
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   task automatic add_token(input logic [2:0] kind, input logic [3:0] code,
                            input logic [30:0] value, input logic [15:0] start, input int len);
      token_beat t;
      t.closes_byte = 1'b0;
      t.tok.kind    = kind;
      t.tok.code    = code;
      t.tok.value   = value;
      t.tok.start   = start;
      t.tok.length  = (len > LEN_MAX) ? LEN_MAX : len[15:0];
      byte_tokens.push_back(t);
   endtask

   task automatic clear_state();
      scan_state = MODE_IDLE;
      foreach (word_bytes[i]) word_bytes[i] = 8'h00;
      word_len   = 0;
      number_val = 0;
      token_at   = '0;
      byte_at    = '0;
   endtask

   task automatic close_word();
      string kw;
      bit    same;
      if (word_len <= WORD_KEEP) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            kw = keyword(k);
            if (kw.len() == word_len) begin
               same = 1'b1;
               for (int i = 0; i < word_len; i++)
                  if (kw.getc(i) != word_bytes[i]) same = 1'b0;
               if (same) begin
                  add_token(KIND_KEY, 4'(k), '0, token_at, word_len);
                  return;
               end
            end
         end
      end
      add_token(KIND_IDENT, '0, '0, token_at, word_len);
   endtask

   task automatic close_pending();
      case (scan_state)
         MODE_WORD: begin
            close_word();
            scan_state = MODE_IDLE;
         end
         MODE_NUMBER: begin
            add_token(KIND_NUM, '0, number_val[30:0], token_at, word_len);
            scan_state = MODE_IDLE;
         end
         MODE_LT: begin
            add_token(KIND_PUNCT, P_LT, '0, token_at, 1);
            scan_state = MODE_IDLE;
         end
         MODE_GT: begin
            add_token(KIND_PUNCT, P_GT, '0, token_at, 1);
            scan_state = MODE_IDLE;
         end
         MODE_COLON: begin
            add_token(KIND_ERR, '0, '0, token_at, 1);
            scan_state = MODE_ERROR;
         end
         default: ;
      endcase
   endtask

   task automatic lex_byte(input logic [7:0] c, input logic fin);
      logic [15:0] pos;
      bit          taken;
      int          p;
      token_beat   t;
      pos   = byte_at;
      taken = 1'b0;
      case (scan_state)
         MODE_ERROR: taken = 1'b1;
         MODE_LT: begin
            if (c == ">" || c == "=") begin
               add_token(KIND_PUNCT, (c == ">") ? P_NE : P_LE, '0, token_at, 2);
               scan_state = MODE_IDLE;
               taken = 1'b1;
            end
         end
         MODE_GT: begin
            if (c == "=") begin
               add_token(KIND_PUNCT, P_GE, '0, token_at, 2);
               scan_state = MODE_IDLE;
               taken = 1'b1;
            end
         end
         MODE_COLON: begin
            if (c == "=") begin
               add_token(KIND_PUNCT, P_BECOMES, '0, token_at, 2);
               scan_state = MODE_IDLE;
            end else begin
               add_token(KIND_ERR, '0, '0, token_at, 1);
               scan_state = MODE_ERROR;
            end
            taken = 1'b1;
         end
         MODE_WORD: begin
            if (is_letter(c) || is_digit(c)) begin
               if (word_len < WORD_KEEP) word_bytes[word_len] = c;
               if (word_len < LEN_MAX) word_len++;
               taken = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c)) begin
               number_val = number_val * 10 + (c - "0");
               if (number_val > NUM_MAX) number_val = NUM_MAX;
               if (word_len < LEN_MAX) word_len++;
               taken = 1'b1;
            end
         end
         default: ;
      endcase

      if (!taken) begin
         close_pending();
         if (is_blank(c)) begin
         end else if (c == "<") begin
            scan_state = MODE_LT;
            token_at   = pos;
         end else if (c == ">") begin
            scan_state = MODE_GT;
            token_at   = pos;
         end else if (c == ":") begin
            scan_state = MODE_COLON;
            token_at   = pos;
         end else if (is_digit(c)) begin
            scan_state = MODE_NUMBER;
            number_val = c - "0";
            word_len   = 1;
            token_at   = pos;
         end else if (is_letter(c)) begin
            scan_state    = MODE_WORD;
            word_bytes[0] = c;
            word_len      = 1;
            token_at      = pos;
         end else begin
            p = punct_code(c);
            if (p >= 0) begin
               add_token(KIND_PUNCT, 4'(p), '0, pos, 1);
            end else begin
               add_token(KIND_ERR, '0, '0, pos, 1);
               scan_state = MODE_ERROR;
            end
         end
      end

      if (fin) begin
         close_pending();
         add_token(KIND_END, '0, '0, pos + 16'd1, 0);
         clear_state();
      end else begin
         byte_at = pos + 16'd1;
      end

      if (byte_tokens.size() > 0) begin
         t = byte_tokens.pop_back();
         t.closes_byte = 1'b1;
         byte_tokens.push_back(t);
      end
      while (byte_tokens.size() > 0) due_tokens.push_back(byte_tokens.pop_front());
   endtask

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      token_beat want;
      if (reset) begin
         clear_state();
         due_tokens.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_tokens.size() == 0) begin
               $error("token with none due: kind %0d start %0d", rsp_tuser, rsp_tdata[50:35]);
               mismatches++;
            end else begin
               want = due_tokens.pop_front();
               check_field("kind", want.tok.kind, rsp_tuser);
               check_field("code", want.tok.code, rsp_tdata[3:0]);
               check_field("value", want.tok.value, rsp_tdata[34:4]);
               check_field("start_res", want.tok.start, rsp_tdata[50:35]);
               check_field("length", want.tok.length, rsp_tdata[66:51]);
               check_field("final_res", want.closes_byte, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) lex_byte(req_tdata, req_tlast);
      end
      tokens_due = due_tokens.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the PL/0 token scanner: clock, reset, source text stimulus and verdict.
module tb;
   import pl0ts_pkg::*;

   localparam logic [95:0] PUNCT_CHARS = "+-*/()=<>,.;";
   localparam int          RANDOM_BYTES = 195;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   int          mismatches;
   int          tokens_due;
   bit          steady;
   int          sent;
   logic [7:0]  src [$];

   pl0_token_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   pl0ts_checker token_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mismatches (mismatches),
      .tokens_due (tokens_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL pl0_token_scanner");
      $finish;
   end

   initial begin : sink
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = steady ? 0 : $urandom_range(0, 4);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_byte(input logic [7:0] ch, input logic fin);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send_source();
      for (int i = 0; i < src.size(); i++) send_byte(src[i], i == src.size() - 1);
      src.delete();
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) src.push_back(s.getc(i));
   endtask

   function automatic logic [7:0] random_letter();
      return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_alnum();
      return $urandom_range(0, 2) == 0 ? 8'("0" + $urandom_range(0, 9)) : random_letter();
   endfunction

   task automatic add_blank();
      int b;
      repeat ($urandom_range(1, 2)) begin
         b = $urandom_range(9, 14);
         src.push_back(b == 14 ? " " : 8'(b));
      end
   endtask

   task automatic add_word_token();
      int pick;
      int k;
      int n;
      int len;
      logic [KW_TEXT_BITS-1:0] text;
      pick = $urandom_range(0, 16);
      if (pick < 4) begin
         k    = $urandom_range(0, KW_COUNT - 1);
         text = kw_text(4'(k));
         len  = kw_len(4'(k));
         n    = ($urandom_range(0, 3) == 0 && len > 1) ? len - 1 : len;
         for (int i = 0; i < n; i++) src.push_back(text[8*(len-1-i) +: 8]);
         if ($urandom_range(0, 3) == 1) src.push_back(random_alnum());
      end else if (pick < 7) begin
         src.push_back(random_letter());
         repeat ($urandom_range(0, 9)) src.push_back(random_alnum());
      end else if (pick < 10) begin
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
         repeat (n) src.push_back(8'("0" + $urandom_range(0, 9)));
      end else if (pick < 14) begin
         k = $urandom_range(0, 11);
         src.push_back(PUNCT_CHARS[8*k +: 8]);
      end else begin
         case ($urandom_range(0, 3))
            0:       queue_text("<>");
            1:       queue_text("<=");
            2:       queue_text(">=");
            default: queue_text(":=");
         endcase
      end
   endtask

   task automatic add_noise();
      if ($urandom_range(0, 1) == 0) begin
         src.push_back(8'($urandom_range(0, 255)));
      end else begin
         src.push_back(":");
         src.push_back(random_letter());
      end
   endtask

   task automatic build_source();
      int tokens;
      int noise_at;
      tokens   = $urandom_range(1, 10);
      noise_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, tokens - 1) : -1;
      for (int t = 0; t < tokens; t++) begin
         if (t == noise_at) add_noise();
         else add_word_token();
         if ($urandom_range(0, 2) != 0) add_blank();
      end
   endtask

   initial begin : stimulus
      int random_start;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      steady     = 1'b0;
      sent       = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_text("if<=9999999999:");
      send_source();
      queue_text("x>");
      send_source();
      queue_text(":a");
      src.push_back(8'hFF);
      queue_text("b");
      send_source();
      src.push_back(8'h00);
      send_source();
      queue_text("ab$");
      send_source();

      random_start = sent;
      while (sent - random_start < RANDOM_BYTES) begin
         steady = ($urandom_range(0, 3) == 0);
         build_source();
         send_source();
      end
      steady = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tokens_due != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS pl0_token_scanner");
      end else begin
         $display("FAIL pl0_token_scanner");
      end
      $finish;
   end

endmodule
